FILE: src/lpf_pkg.sv
// Shared types, codes and constants of the lookahead path follower.
`timescale 1ns / 1ps
package lpf_pkg;

  localparam int unsigned MaxWaypointsDef = 256;
  localparam int unsigned CordicStepsDef  = 16;

  localparam logic [1:0] MODE_NEW    = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_CANCEL = 2'd3;

  localparam logic [2:0] ST_DRIVE     = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_IDLE      = 3'd3;
  localparam logic [2:0] ST_COMPLETED = 3'd4;
  localparam logic [2:0] ST_CANCELED  = 3'd5;

  localparam logic [1:0] CFG_MAX_LIN = 2'd0;
  localparam logic [1:0] CFG_MAX_ANG = 2'd1;
  localparam logic [1:0] CFG_ARRIVE  = 2'd2;
  localparam logic [1:0] CFG_LOOK    = 2'd3;

  // angles in Q16 radians
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [19:0]        ROT_LIMIT   = 20'd52429;
  localparam logic [15:0]        MIN_TURN    = 16'd1229;
  localparam logic signed [18:0] CURV_FLOOR  = 19'sd13107;
  localparam logic signed [18:0] ONE_Q16     = 19'sd65536;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_DX, S_SQ0, S_SQ1, S_SQ2, S_SQRT, S_SCAN,
    S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_CNORM, S_CITER, S_WRAP,
    S_LIN0, S_LIN1, S_OUT
  } state_e;

  function automatic logic [15:0] atan_lut(input logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30385;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/lpf_in_if.sv
// Input channel of the path follower: command words with pose or waypoint.
`timescale 1ns / 1ps
interface lpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, mode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  output ready);
endinterface

FILE: src/lpf_out_if.sv
// Output channel of the path follower: velocity command words.
`timescale 1ns / 1ps
interface lpf_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        linear_cmd;
  logic signed [15:0] angular_cmd;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, linear_cmd, angular_cmd, status, last, input ready);
  modport sink   (input valid, linear_cmd, angular_cmd, status, last, output ready);
endinterface

FILE: src/lookahead_path_follower_top.sv
// Top level of the lookahead path follower.
`timescale 1ns / 1ps
// Pure-pursuit tracker. Load and cancel words go straight to the output. A pose
// tick runs on one shared multiplier, a bit-serial square root and one CORDIC
// datapath: a memory read, two squares and 21 square-root steps per waypoint
// scanned, then normalize shifts and CORDIC_STEPS iterations each for the yaw
// and target bearing, then the output handshakes. The scan runs from the current
// waypoint to the lookahead point or the path end. No input word is taken until
// all results of the previous word have been delivered.
module lookahead_path_follower_top #(
  parameter int unsigned MAX_WAYPOINTS = lpf_pkg::MaxWaypointsDef,
  parameter int unsigned CORDIC_STEPS  = lpf_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  lpf_in_if.sink      in_i,
  lpf_out_if.source   out_o
);

  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  // configuration
  logic [14:0] max_lin_q, max_ang_q;
  logic [15:0] arrive_q, look_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q <= 15'd2048;
      max_ang_q <= 15'd8192;
      arrive_q  <= 16'd205;
      look_q    <= 16'd614;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpf_pkg::CFG_MAX_LIN: max_lin_q <= cfg_wdata_i[14:0];
        lpf_pkg::CFG_MAX_ANG: max_ang_q <= cfg_wdata_i[14:0];
        lpf_pkg::CFG_ARRIVE:  arrive_q  <= cfg_wdata_i;
        lpf_pkg::CFG_LOOK:    look_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lpf_pkg::state_e state_q, state_d;

  logic [LW-1:0] len_q, len_d, cur_q, cur_d;
  logic          active_q, active_d;
  logic [AW-1:0] idx_q, idx_d;

  logic signed [19:0] px_q, py_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;

  logic [39:0] mem [MAX_WAYPOINTS];
  logic [39:0] rd_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;

  logic signed [21:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [21:0] ma, mb;
  logic signed [43:0] prod_q, acc_q, acc_d, msum;

  logic [41:0] rad_q, rad_d;
  logic [23:0] rem_q, rem_d, remn, trial;
  logic [20:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;

  logic [20:0] tdist_q, tdist_d, cdist_q, cdist_d;
  logic signed [20:0] tdx_q, tdx_d, tdy_q, tdy_d;

  logic signed [40:0] cx_q, cx_d, cy_q, cy_d, xs, ys;
  logic signed [19:0] cz_q, cz_d, yaw_q, yaw_d, znew, atan_s;
  logic [SW-1:0]      citer_q, citer_d;
  logic               csel_q, csel_d, cord_done;
  logic signed [20:0] err_q, err_d;

  logic signed [17:0] ang18, mxang;
  logic signed [15:0] ang_q, ang_d;
  logic               turn_q, turn_d;
  logic [19:0]        abs_err;
  logic signed [18:0] curve;
  logic [14:0]        slow;
  logic [LW-1:0]      cur_next;

  logic [14:0] o_lin_q, o_lin_d;
  logic [15:0] o_ang_q, o_ang_d;
  logic [2:0]  o_st_q, o_st_d;
  logic        o_last_q, o_last_d, two_q, two_d;

  logic in_acc, out_acc, x_small, y_small, scan_end;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready        = (state_q == lpf_pkg::S_IDLE);
  assign out_o.valid       = (state_q == lpf_pkg::S_OUT);
  assign out_o.linear_cmd  = o_lin_q;
  assign out_o.angular_cmd = o_ang_q;
  assign out_o.status      = o_st_q;
  assign out_o.last        = o_last_q;

  // waypoint memory: one write port, one registered read port
  assign mem_we    = in_acc && ((in_i.mode == lpf_pkg::MODE_NEW) ||
                     ((in_i.mode == lpf_pkg::MODE_APPEND) && (len_q < LW'(MAX_WAYPOINTS))));
  assign mem_waddr = (in_i.mode == lpf_pkg::MODE_NEW) ? '0 : len_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= {in_i.pos_x, in_i.pos_y};
    rd_q <= mem[idx_q];
  end

  // shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      lpf_pkg::S_SQ0:  begin ma = dx_q; mb = dx_q; end
      lpf_pkg::S_SQ1:  begin ma = dy_q; mb = dy_q; end
      lpf_pkg::S_Q0:   begin ma = 22'(qw_q); mb = 22'(qz_q); end
      lpf_pkg::S_Q1:   begin ma = 22'(qx_q); mb = 22'(qy_q); end
      lpf_pkg::S_Q2:   begin ma = 22'(qy_q); mb = 22'(qy_q); end
      lpf_pkg::S_Q3:   begin ma = 22'(qz_q); mb = 22'(qz_q); end
      lpf_pkg::S_LIN0: begin ma = $signed({7'd0, slow}); mb = $signed({3'd0, curve}); end
      default: ;
    endcase
  end

  assign msum = acc_q + prod_q;

  // combinational helpers
  assign remn  = {rem_q[21:0], rad_q[41:40]};
  assign trial = {1'b0, root_q, 2'b01};
  assign x_small = (cx_q < (41'sd1 <<< 36)) && (cx_q > -(41'sd1 <<< 36));
  assign y_small = (cy_q < (41'sd1 <<< 36)) && (cy_q > -(41'sd1 <<< 36));
  assign xs = cx_q >>> citer_q;
  assign ys = cy_q >>> citer_q;
  assign atan_s = $signed({4'd0, lpf_pkg::atan_lut(5'(citer_q))});
  assign scan_end = (root_q >= {5'd0, look_q}) || (({1'b0, idx_q} + LW'(1)) == len_q);
  assign ang18 = 18'(err_q >>> 3);
  assign mxang = $signed({3'd0, max_ang_q});
  assign abs_err = err_q[20] ? 20'(-err_q) : err_q[19:0];
  assign curve = ((ONE_Q16() - 19'($signed({1'b0, abs_err, 1'b0} + {2'b0, abs_err}) >>> 1))
                  < lpf_pkg::CURV_FLOOR) ? lpf_pkg::CURV_FLOOR
                 : (ONE_Q16() - 19'($signed({1'b0, abs_err, 1'b0} + {2'b0, abs_err}) >>> 1));
  assign slow = (tdist_q < {6'd0, max_lin_q}) ? tdist_q[14:0] : max_lin_q;
  assign cur_next = (cdist_q < {5'd0, arrive_q}) ? cur_q + LW'(1) : cur_q;

  function automatic logic signed [18:0] ONE_Q16();
    return lpf_pkg::ONE_Q16;
  endfunction

  // CORDIC vectoring step
  always_comb begin
    znew = (cy_q > 0) ? cz_q + atan_s : cz_q - atan_s;
    cord_done = (state_q == lpf_pkg::S_CITER) && (citer_q == SW'(CORDIC_STEPS - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpf_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_i.mode == lpf_pkg::MODE_TICK && active_q && (cur_q < len_q))
            state_d = lpf_pkg::S_RD;
          else
            state_d = lpf_pkg::S_OUT;
        end
      end
      lpf_pkg::S_RD:   state_d = lpf_pkg::S_DX;
      lpf_pkg::S_DX:   state_d = lpf_pkg::S_SQ0;
      lpf_pkg::S_SQ0:  state_d = lpf_pkg::S_SQ1;
      lpf_pkg::S_SQ1:  state_d = lpf_pkg::S_SQ2;
      lpf_pkg::S_SQ2:  state_d = lpf_pkg::S_SQRT;
      lpf_pkg::S_SQRT: if (cnt_q == 5'd20) state_d = lpf_pkg::S_SCAN;
      lpf_pkg::S_SCAN: state_d = scan_end ? lpf_pkg::S_Q0 : lpf_pkg::S_RD;
      lpf_pkg::S_Q0:   state_d = lpf_pkg::S_Q1;
      lpf_pkg::S_Q1:   state_d = lpf_pkg::S_Q2;
      lpf_pkg::S_Q2:   state_d = lpf_pkg::S_Q3;
      lpf_pkg::S_Q3:   state_d = lpf_pkg::S_Q4;
      lpf_pkg::S_Q4:   state_d = lpf_pkg::S_CNORM;
      lpf_pkg::S_CNORM: begin
        if (cx_q == 0 && cy_q == 0)
          state_d = csel_q ? lpf_pkg::S_WRAP : lpf_pkg::S_CNORM;
        else if (!(x_small && y_small))
          state_d = lpf_pkg::S_CITER;
      end
      lpf_pkg::S_CITER: begin
        if (cord_done) state_d = csel_q ? lpf_pkg::S_WRAP : lpf_pkg::S_CNORM;
      end
      lpf_pkg::S_WRAP: begin
        if (!(err_q > lpf_pkg::PI_Q16) && !(err_q < -lpf_pkg::PI_Q16))
          state_d = lpf_pkg::S_LIN0;
      end
      lpf_pkg::S_LIN0: state_d = lpf_pkg::S_LIN1;
      lpf_pkg::S_LIN1: state_d = lpf_pkg::S_OUT;
      lpf_pkg::S_OUT: begin
        if (out_acc && !two_q) state_d = lpf_pkg::S_IDLE;
      end
      default: state_d = lpf_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_d = len_q; cur_d = cur_q; active_d = active_q; idx_d = idx_q;
    dx_d = dx_q; dy_d = dy_q; acc_d = acc_q;
    rad_d = rad_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q;
    tdist_d = tdist_q; cdist_d = cdist_q; tdx_d = tdx_q; tdy_d = tdy_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; citer_d = citer_q; csel_d = csel_q;
    yaw_d = yaw_q; err_d = err_q; ang_d = ang_q; turn_d = turn_q;
    o_lin_d = o_lin_q; o_ang_d = o_ang_q; o_st_d = o_st_q; o_last_d = o_last_q;
    two_d = two_q;
    unique case (state_q)
      lpf_pkg::S_IDLE: begin
        if (in_acc) begin
          o_lin_d = '0; o_ang_d = '0; o_last_d = 1'b1; two_d = 1'b0;
          idx_d = cur_q[AW-1:0];
          unique case (in_i.mode)
            lpf_pkg::MODE_NEW: begin
              len_d = LW'(1); cur_d = '0; active_d = 1'b1;
              o_st_d = lpf_pkg::ST_STORED;
            end
            lpf_pkg::MODE_APPEND: begin
              if (len_q < LW'(MAX_WAYPOINTS)) begin
                len_d = len_q + LW'(1);
                o_st_d = lpf_pkg::ST_STORED;
              end else begin
                o_st_d = lpf_pkg::ST_FULL;
              end
            end
            lpf_pkg::MODE_CANCEL: begin
              active_d = 1'b0;
              o_st_d = lpf_pkg::ST_CANCELED;
            end
            default: o_st_d = lpf_pkg::ST_IDLE;
          endcase
        end
      end
      lpf_pkg::S_DX: begin
        dx_d = 22'($signed(rd_q[39:20])) - 22'(px_q);
        dy_d = 22'($signed(rd_q[19:0])) - 22'(py_q);
      end
      lpf_pkg::S_SQ1: acc_d = prod_q;
      lpf_pkg::S_SQ2: begin
        rad_d = msum[41:0]; rem_d = '0; root_d = '0; cnt_d = '0;
      end
      lpf_pkg::S_SQRT: begin
        if (remn >= trial) begin
          rem_d = remn - trial; root_d = {root_q[19:0], 1'b1};
        end else begin
          rem_d = remn; root_d = {root_q[19:0], 1'b0};
        end
        rad_d = {rad_q[39:0], 2'b00};
        cnt_d = cnt_q + 5'd1;
      end
      lpf_pkg::S_SCAN: begin
        if ({1'b0, idx_q} == cur_q) cdist_d = root_q;
        tdist_d = root_q;
        tdx_d = dx_q[20:0];
        tdy_d = dy_q[20:0];
        if (!scan_end) idx_d = idx_q + AW'(1);
      end
      lpf_pkg::S_Q1: acc_d = prod_q;
      lpf_pkg::S_Q2: cy_d = {msum[39:0], 1'b0};
      lpf_pkg::S_Q3: acc_d = prod_q;
      lpf_pkg::S_Q4: begin
        cx_d = (41'sd1 <<< 28) - {msum[39:0], 1'b0};
        cz_d = '0; csel_d = 1'b0;
      end
      lpf_pkg::S_CNORM: begin
        citer_d = '0;
        if (cx_q == 0 && cy_q == 0) begin
          // zero vector: angle is zero
          if (csel_q) begin
            err_d = 21'sd0 - 21'(yaw_q);
          end else begin
            yaw_d = '0;
            cx_d = 41'(tdx_q); cy_d = 41'(tdy_q); cz_d = '0; csel_d = 1'b1;
          end
        end else if (x_small && y_small) begin
          cx_d = cx_q <<< 1; cy_d = cy_q <<< 1;
        end else if (cx_q < 0) begin
          if (cy_q >= 0) begin
            cx_d = cy_q; cy_d = -cx_q; cz_d = lpf_pkg::HALF_PI_Q16;
          end else begin
            cx_d = -cy_q; cy_d = cx_q; cz_d = -lpf_pkg::HALF_PI_Q16;
          end
        end else begin
          cz_d = '0;
        end
      end
      lpf_pkg::S_CITER: begin
        if (cy_q > 0) begin
          cx_d = cx_q + ys; cy_d = cy_q - xs;
        end else begin
          cx_d = cx_q - ys; cy_d = cy_q + xs;
        end
        cz_d = znew;
        citer_d = citer_q + SW'(1);
        if (cord_done) begin
          if (csel_q) begin
            err_d = 21'(znew) - 21'(yaw_q);
          end else begin
            yaw_d = znew;
            cx_d = 41'(tdx_q); cy_d = 41'(tdy_q); cz_d = '0; csel_d = 1'b1;
          end
        end
      end
      lpf_pkg::S_WRAP: begin
        if (err_q > lpf_pkg::PI_Q16) begin
          err_d = err_q - lpf_pkg::TWO_PI_Q16;
        end else if (err_q < -lpf_pkg::PI_Q16) begin
          err_d = err_q + lpf_pkg::TWO_PI_Q16;
        end else begin
          turn_d = abs_err > lpf_pkg::ROT_LIMIT;
          if (ang18 > mxang)       ang_d = 16'(mxang);
          else if (ang18 < -mxang) ang_d = 16'(-mxang);
          else                     ang_d = 16'(ang18);
        end
      end
      lpf_pkg::S_LIN0: begin
        // enforce a minimum turn rate when rotating in place
        if (turn_q && (ang_q < $signed(lpf_pkg::MIN_TURN)) &&
            (ang_q > -$signed(lpf_pkg::MIN_TURN)))
          ang_d = (ang_q > 0) ? $signed(lpf_pkg::MIN_TURN) : -$signed(lpf_pkg::MIN_TURN);
      end
      lpf_pkg::S_LIN1: begin
        o_lin_d = turn_q ? 15'd0 : prod_q[30:16];
        o_ang_d = 16'(-ang_q);
        o_st_d = lpf_pkg::ST_DRIVE;
        cur_d = cur_next;
        if (cur_next >= len_q) begin
          active_d = 1'b0; two_d = 1'b1; o_last_d = 1'b0;
        end else begin
          o_last_d = 1'b1;
        end
      end
      lpf_pkg::S_OUT: begin
        if (out_acc && two_q) begin
          two_d = 1'b0;
          o_lin_d = '0; o_ang_d = '0; o_st_d = lpf_pkg::ST_COMPLETED; o_last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lpf_pkg::S_IDLE;
      len_q    <= '0;
      cur_q    <= '0;
      active_q <= 1'b0;
      two_q    <= 1'b0;
      csel_q   <= 1'b0;
      citer_q  <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      cur_q    <= cur_d;
      active_q <= active_d;
      two_q    <= two_d;
      csel_q   <= csel_d;
      citer_q  <= citer_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_i.pos_x; py_q <= in_i.pos_y;
      qx_q <= in_i.quat_x; qy_q <= in_i.quat_y;
      qz_q <= in_i.quat_z; qw_q <= in_i.quat_w;
    end
    prod_q <= ma * mb;
    acc_q <= acc_d; dx_q <= dx_d; dy_q <= dy_d;
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
    tdist_q <= tdist_d; cdist_q <= cdist_d; tdx_q <= tdx_d; tdy_q <= tdy_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; yaw_q <= yaw_d; err_q <= err_d;
    ang_q <= ang_d; turn_q <= turn_d;
    o_lin_q <= o_lin_d; o_ang_q <= o_ang_d; o_st_q <= o_st_d; o_last_q <= o_last_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input ready while result pending");

  a_cur_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q <= len_q) && (len_q <= LW'(MAX_WAYPOINTS)))
    else $error("waypoint index beyond path");

  a_stop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=>
    (out_o.valid && out_o.status == lpf_pkg::ST_COMPLETED && out_o.last))
    else $error("completion stop missing after final drive word");

  a_full_only_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == lpf_pkg::ST_FULL) |-> (len_q == LW'(MAX_WAYPOINTS)))
    else $error("path full reported below capacity");

endmodule

FILE: test/lookahead_path_follower_top_tb.sv
// Testbench of the lookahead path follower: self-checking, with its own predictor.
`timescale 1ns / 1ps
module lookahead_path_follower_top_tb;
  import lpf_pkg::*;

  localparam int unsigned PATH_DEPTH = 256;
  localparam int unsigned ROT_STEPS  = 16;
  localparam int unsigned QUIET_MAX  = 40000;
  localparam int unsigned HOLD_LONG  = 3000;
  localparam int unsigned ITEM_GOAL  = 1700;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } cmd_t;

  typedef struct packed {
    logic [14:0] lin;
    logic [15:0] ang;
    logic [2:0]  st;
    logic        last;
  } vel_t;

  typedef struct packed {
    logic       typed;
    logic [2:0] st;
  } status_pin_t;

  typedef struct packed {
    cmd_t       c;
    logic       typed;
    logic [2:0] st;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_MAX_LIN;
  logic [15:0] cfg_wdata_i = '0;

  lpf_in_if  in_ch ();
  lpf_out_if out_ch ();

  lookahead_path_follower_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state and register copies
  longint wp_x [PATH_DEPTH];
  longint wp_y [PATH_DEPTH];
  int unsigned path_len = 0;
  int unsigned cur_wp = 0;
  bit path_on = 1'b0;
  longint lin_ceiling = 2048;
  longint ang_ceiling = 8192;
  longint arrive_dist = 205;
  longint look_dist = 614;

  vel_t        vel_due [$];
  status_pin_t pinned [$];
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned quiet = 0;
  bit hold_req = 1'b0;
  int unsigned rx_style = 0;
  bit tx_steady = 1'b0;
  int unsigned burst_left = 0;

  localparam longint BEARING_STEP [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
                                           512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint span(longint dx, longint dy);
    return root_floor(longint'(dx * dx + dy * dy));
  endfunction

  function automatic longint bearing(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (mag(x) < (64'sd1 <<< 36) && mag(y) < (64'sd1 <<< 36)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q16;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + BEARING_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - BEARING_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic vel_t make_vel(longint lin, longint ang, logic [2:0] st, logic last);
    vel_t v;
    v.lin  = lin[14:0];
    v.ang  = ang[15:0];
    v.st   = st;
    v.last = last;
    return v;
  endfunction

  // work out the words one command produces and update the tracked path
  task automatic follow(input cmd_t c);
    longint tdx, tdy, tdist, cdist, yaw, err, lin, ang, curve, slow;
    tdx = 0; tdy = 0; tdist = 0;
    case (c.mode)
      MODE_NEW: begin
        wp_x[0] = c.px; wp_y[0] = c.py;
        path_len = 1; cur_wp = 0; path_on = 1'b1;
        vel_due.push_back(make_vel(0, 0, ST_STORED, 1'b1));
      end
      MODE_APPEND: begin
        if (path_len < PATH_DEPTH) begin
          wp_x[path_len] = c.px; wp_y[path_len] = c.py;
          path_len++;
          vel_due.push_back(make_vel(0, 0, ST_STORED, 1'b1));
        end else begin
          vel_due.push_back(make_vel(0, 0, ST_FULL, 1'b1));
        end
      end
      MODE_CANCEL: begin
        path_on = 1'b0;
        vel_due.push_back(make_vel(0, 0, ST_CANCELED, 1'b1));
      end
      default: begin
        if (!path_on || cur_wp >= path_len) begin
          vel_due.push_back(make_vel(0, 0, ST_IDLE, 1'b1));
        end else begin
          for (int unsigned i = cur_wp; i < path_len; i++) begin
            tdx = wp_x[i] - c.px;
            tdy = wp_y[i] - c.py;
            tdist = span(tdx, tdy);
            if (tdist >= look_dist) break;
          end
          cdist = span(wp_x[cur_wp] - c.px, wp_y[cur_wp] - c.py);
          yaw = bearing(2 * (longint'(c.qw) * c.qz + longint'(c.qx) * c.qy),
                        (64'sd1 <<< 28) - 2 * (longint'(c.qy) * c.qy + longint'(c.qz) * c.qz));
          err = bearing(tdy, tdx) - yaw;
          while (err > PI_Q16) err = err - TWO_PI_Q16;
          while (err < -PI_Q16) err = err + TWO_PI_Q16;
          ang = err >>> 3;
          if (ang > ang_ceiling) ang = ang_ceiling;
          if (ang < -ang_ceiling) ang = -ang_ceiling;
          if (mag(err) > ROT_LIMIT) begin
            lin = 0;
            if (mag(ang) < MIN_TURN) ang = ang > 0 ? MIN_TURN : -longint'(MIN_TURN);
          end else begin
            curve = ONE_Q16 - ((3 * mag(err)) >>> 1);
            slow = tdist < lin_ceiling ? tdist : lin_ceiling;
            if (curve < CURV_FLOOR) curve = CURV_FLOOR;
            lin = (slow * curve) >>> 16;
            if (lin > lin_ceiling) lin = lin_ceiling;
            if (lin < 0) lin = 0;
          end
          ang = -ang;
          if (cdist < arrive_dist) cur_wp++;
          if (cur_wp >= path_len) begin
            path_on = 1'b0;
            vel_due.push_back(make_vel(lin, ang, ST_DRIVE, 1'b0));
            vel_due.push_back(make_vel(0, 0, ST_COMPLETED, 1'b1));
          end else begin
            vel_due.push_back(make_vel(lin, ang, ST_DRIVE, 1'b1));
          end
        end
      end
    endcase
  endtask

  // monitors and watchdog
  always @(posedge clk_i) begin
    cmd_t c;
    status_pin_t p;
    vel_t got, want;
    if (rst_ni) begin
      quiet <= quiet + 1;
      if (in_ch.valid && in_ch.ready) begin
        quiet <= 0;
        c = '{in_ch.mode, in_ch.pos_x, in_ch.pos_y, in_ch.quat_x, in_ch.quat_y,
              in_ch.quat_z, in_ch.quat_w};
        follow(c);
        p = pinned.pop_front();
        // rows with a hand-typed status replace the predicted word
        if (p.typed) vel_due[vel_due.size() - 1] = make_vel(0, 0, p.st, 1'b1);
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet <= 0;
        got = '{out_ch.linear_cmd, out_ch.angular_cmd, out_ch.status, out_ch.last};
        if (vel_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: lin %0d ang %0d st %0d last %0d",
                                     got.lin, $signed(got.ang), got.st, got.last);
        end else begin
          want = vel_due.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp lin %0d ang %0d st %0d last %0d, got lin %0d ang %0d st %0d last %0d",
                       want.lin, $signed(want.ang), want.st, want.last,
                       got.lin, $signed(got.ang), got.st, got.last);
          end
        end
      end
      if (quiet >= QUIET_MAX) begin
        $display("lookahead_path_follower_top_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: stall patterns and one long hold-off on request
  initial begin
    int unsigned phase;
    phase = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LONG) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        case (rx_style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 9) < 7);
          default: out_ch.ready <= (phase % 5) < 2;
        endcase
      end
    end
  end

  task automatic send(input cmd_t c, input logic typed = 1'b0,
                      input logic [2:0] st = ST_DRIVE);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!tx_steady && $urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    pinned.push_back('{typed, st});
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= c.mode;
    in_ch.pos_x  <= c.px;
    in_ch.pos_y  <= c.py;
    in_ch.quat_x <= c.qx;
    in_ch.quat_y <= c.qy;
    in_ch.quat_z <= c.qz;
    in_ch.quat_w <= c.qw;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // drop valid and hold until every word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (vel_due.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_LIN: lin_ceiling = val[14:0];
      CFG_MAX_ANG: ang_ceiling = val[14:0];
      CFG_ARRIVE:  arrive_dist = val;
      default:     look_dist = val;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] l, a, t, k);
    write_reg(CFG_MAX_LIN, l);
    write_reg(CFG_MAX_ANG, a);
    write_reg(CFG_ARRIVE, t);
    write_reg(CFG_LOOK, k);
  endtask

  function automatic cmd_t make_cmd(logic [1:0] m, longint x, longint y);
    cmd_t c;
    longint qz, qw;
    c.mode = m;
    c.px = x[19:0];
    c.py = y[19:0];
    if ($urandom_range(0, 4) == 0) begin
      c.qx = $urandom_range(0, 32768) - 16384;
      c.qy = $urandom_range(0, 32768) - 16384;
      c.qz = $urandom_range(0, 32768) - 16384;
      c.qw = $urandom_range(0, 32768) - 16384;
    end else begin
      // planar heading: unit quaternion about z
      qz = longint'($urandom_range(0, 32768)) - 16384;
      qw = root_floor(16384 * 16384 - qz * qz);
      if ($urandom_range(0, 1)) qw = -qw;
      c.qx = 0; c.qy = 0; c.qz = qz[15:0]; c.qw = qw[15:0];
    end
    return c;
  endfunction

  function automatic longint near(longint v, longint r);
    longint n;
    n = v + longint'($urandom_range(0, 2 * r)) - r;
    if (n > 524287) n = 524287;
    if (n < -524288) n = -524288;
    return n;
  endfunction

  // one path: load, then ticks that walk it, with some noise
  task automatic run_path(input int unsigned pts, input longint stride);
    longint xs [$], ys [$];
    longint x, y, wob;
    int unsigned k;
    cmd_t c;
    if ($urandom_range(0, 5) == 0) begin
      x = longint'($urandom) % 524288; y = longint'($urandom) % 524288;
    end else begin
      x = near(0, 20000); y = near(0, 20000);
    end
    for (int unsigned i = 0; i < pts; i++) begin
      xs.push_back(x); ys.push_back(y);
      send(make_cmd(i == 0 ? MODE_NEW : MODE_APPEND, x, y));
      x = near(x, stride); y = near(y, stride);
    end
    k = 0;
    wob = arrive_dist > 4 ? arrive_dist / 2 : 2;
    for (int unsigned i = 0; i < pts * 3; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = make_cmd(2'($urandom), $urandom, $urandom);
        send(c);
      end else begin
        send(make_cmd(MODE_TICK, near(xs[k], wob), near(ys[k], wob)));
        if (k < pts - 1 && $urandom_range(0, 2) != 0) k++;
      end
    end
    if ($urandom_range(0, 3) == 0) send(make_cmd(MODE_CANCEL, 0, 0));
  endtask

  initial begin
    row_t rows [20];
    int unsigned ph;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.pos_x = '0; in_ch.pos_y = '0;
    in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0; in_ch.quat_w = '0;
    rows = '{
      '{'{MODE_TICK, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, ST_IDLE},
      '{'{MODE_CANCEL, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_CANCELED},
      '{'{MODE_APPEND, 20'sd5, 20'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_STORED},
      '{'{MODE_TICK, 20'sd5, 20'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, ST_IDLE},
      '{'{MODE_NEW, 20'sd524287, 20'sd524287, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_STORED},
      '{'{MODE_APPEND, -20'sd524288, -20'sd524288, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        1'b1, ST_STORED},
      '{'{MODE_APPEND, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_STORED},
      '{'{MODE_TICK, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, ST_DRIVE},
      '{'{MODE_TICK, -20'sd524288, 20'sd524287, 16'sd16384, 16'sd16384, 16'sd16384,
          16'sd16384}, 1'b0, ST_DRIVE},
      '{'{MODE_TICK, 20'sd524287, -20'sd524288, -16'sd16384, -16'sd16384, -16'sd16384,
          -16'sd16384}, 1'b0, ST_DRIVE},
      '{'{MODE_TICK, 20'sd100, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ST_DRIVE},
      '{'{MODE_TICK, 20'sd524287, 20'sd524287, 16'sd0, 16'sd0, 16'sd16384, 16'sd0},
        1'b0, ST_DRIVE},
      '{'{MODE_TICK, -20'sd524288, -20'sd524288, 16'sd0, 16'sd0, -16'sd11585, 16'sd11585},
        1'b0, ST_DRIVE},
      '{'{MODE_TICK, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, ST_DRIVE},
      '{'{MODE_TICK, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, ST_IDLE},
      '{'{MODE_NEW, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_STORED},
      // robot on the only point: zero bearing vector, then completion
      '{'{MODE_TICK, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, ST_DRIVE},
      '{'{MODE_NEW, 20'sd4096, -20'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_STORED},
      '{'{MODE_CANCEL, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ST_CANCELED},
      '{'{MODE_TICK, 20'sd4096, -20'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
        1'b1, ST_IDLE}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].st);
    drain();

    // fill the store past its depth, then scan it end to end
    set_regs(16'd16384, 16'd32767, 16'd0, 16'd65535);
    tx_steady = 1'b1;
    for (int unsigned i = 0; i < PATH_DEPTH + 4; i++)
      send(make_cmd(i == 0 ? MODE_NEW : MODE_APPEND, near(0, 2000), near(0, 2000)));
    tx_steady = 1'b0;
    rx_style = 1;
    repeat (2) send(make_cmd(MODE_TICK, 0, 0));
    drain();

    ph = 0;
    while (items_sent < ITEM_GOAL) begin
      case (ph % 5)
        0: set_regs(16'd0, 16'd0, 16'd0, 16'd0);
        1: set_regs(16'd16384, 16'd32767, 16'd65535, 16'd65535);
        2: set_regs(16'd2048, 16'd8192, 16'd205, 16'd614);
        default: set_regs($urandom_range(0, 16384), $urandom_range(0, 32767),
                          $urandom_range(0, 8192), $urandom_range(0, 16384));
      endcase
      rx_style = $urandom_range(0, 2);
      tx_steady = ($urandom_range(0, 3) == 0);
      if (ph == 3) hold_req = 1'b1;
      repeat (4) run_path($urandom_range(1, 8), $urandom_range(50, 8000));
      drain();
      ph++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("lookahead_path_follower_top_tb: done, clean");
    end else begin
      $display("lookahead_path_follower_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lpf_pkg.sv
src/lpf_in_if.sv
src/lpf_out_if.sv
src/lookahead_path_follower_top.sv
test/lookahead_path_follower_top_tb.sv
